>>> src/sphere_capsule_overlap_test_unit_defines.svh
// ----------------------------------------------------------------------------
// Sphere-capsule overlap test assertion macros
// Shared property shorthands for the checker, clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef SPHERE_CAPSULE_OVERLAP_TEST_UNIT_DEFINES_SVH
`define SPHERE_CAPSULE_OVERLAP_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define SCOT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define SCOT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/scot_pkg.sv
// ----------------------------------------------------------------------------
// Sphere-capsule overlap test package
// Widths, register codes, the input word layout and small arithmetic helpers.
// ----------------------------------------------------------------------------
package scot_pkg;

  localparam int COORD_W    = 24;
  localparam int RADIUS_W   = 23;
  localparam int EXTRA_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;        // coordinate difference
  localparam int RAD_W      = RADIUS_W + 1;       // combined radius
  localparam int PROD_W     = 2 * DIFF_W;         // signed 25x25 product
  localparam int DOT_W      = PROD_W + 2;         // sum of three products
  localparam int CROSS_W    = PROD_W + 1;         // one cross component
  localparam int ABS_W      = PROD_W;             // magnitude of a cross component
  localparam int HALF_W     = ABS_W / 2;          // multiplier slice
  localparam int PP_W       = 2 * HALF_W;         // partial product
  localparam int RR_W       = 2 * RAD_W;          // radius squared
  localparam int AA_W       = PROD_W;             // axis length squared
  localparam int WIDE_W     = 2 * ABS_W;          // full square / limit
  localparam int WSUM_W     = WIDE_W + 2;         // sum of three squares
  localparam int NUM_STAGES = 8;

  localparam int IN_TDATA_W  = 240;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [EXTRA_W-1:0] EXTRA_RESET = 16'd640;

  // Register index, taken from paddr[2]
  localparam logic [0:0] REG_EXTRA_RADIUS = 1'b0;

  // Input word, start_x in the lowest bits
  typedef struct packed {
    logic                       pad;
    logic        [RADIUS_W-1:0] radius;
    logic signed [COORD_W-1:0]  point_z;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  end_z;
    logic signed [COORD_W-1:0]  end_y;
    logic signed [COORD_W-1:0]  end_x;
    logic signed [COORD_W-1:0]  start_z;
    logic signed [COORD_W-1:0]  start_y;
    logic signed [COORD_W-1:0]  start_x;
  } scot_item_t;

  function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
    sdiff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
  endfunction

  function automatic logic signed [PROD_W-1:0] smul(input logic signed [DIFF_W-1:0] a,
                                                     input logic signed [DIFF_W-1:0] b);
    smul = a * b;
  endfunction

  function automatic logic [PP_W-1:0] umul(input logic [HALF_W-1:0] a,
                                            input logic [HALF_W-1:0] b);
    umul = a * b;
  endfunction

  function automatic logic [RR_W-1:0] rmul(input logic [RAD_W-1:0] a,
                                            input logic [RAD_W-1:0] b);
    rmul = a * b;
  endfunction

  function automatic logic signed [DOT_W-1:0] sum3(input logic signed [PROD_W-1:0] a,
                                                    input logic signed [PROD_W-1:0] b,
                                                    input logic signed [PROD_W-1:0] c);
    sum3 = {{(DOT_W-PROD_W){a[PROD_W-1]}}, a}
         + {{(DOT_W-PROD_W){b[PROD_W-1]}}, b}
         + {{(DOT_W-PROD_W){c[PROD_W-1]}}, c};
  endfunction

  function automatic logic signed [CROSS_W-1:0] csub(input logic signed [PROD_W-1:0] a,
                                                      input logic signed [PROD_W-1:0] b);
    csub = {a[PROD_W-1], a} - {b[PROD_W-1], b};
  endfunction

  function automatic logic [ABS_W-1:0] sabs(input logic signed [CROSS_W-1:0] a);
    logic signed [CROSS_W-1:0] t;
    t = a[CROSS_W-1] ? -a : a;
    sabs = t[ABS_W-1:0];
  endfunction

endpackage

>>> src/sphere_capsule_overlap_test_unit.sv
// ----------------------------------------------------------------------------
// Sphere-capsule overlap test unit
// Streams capsule/sphere queries in and one hit bit per query out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per query: capsule axis start and end, sphere centre
//           and radius, signed fixed point with 8 fraction bits (radius unsigned).
//   out_* : one word per query, in the same order: bit 0 is the hit flag.
//   cfg_* : APB-style port; byte address 0 holds extra_radius (16 bits),
//           added to every input radius. Write it only while the unit idles.
// Throughput: one word per cycle while out_tready stays high; each of the
//   eight stages holds at most one layer of multipliers or one wide add
//   and compare, with the 50-bit squares split over two stages of 25x25
//   partial products.
// Reset (rst_n low, synchronous): empty the pipeline and load extra_radius
//   with 640 (2.5).
// Stall: a stage advances whenever it is empty or the stage after it advances,
//   so bubbles close up and new words keep entering while a finished result
//   waits; with every stage full and out_tready low, in_tready drops.
// ----------------------------------------------------------------------------
module sphere_capsule_overlap_test_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // Query input
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, point_x, point_y,
  // point_z (24 bits each), radius (23 bits), one zero pad bit
  input  logic [scot_pkg::IN_TDATA_W-1:0]     in_tdata,
  // Result output
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // hit (bit 0), zero pad
  output logic [scot_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [scot_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [scot_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [scot_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int NS = scot_pkg::NUM_STAGES;

  // Configuration register
  logic [scot_pkg::EXTRA_W-1:0] extra_r, extra_nxt;
  logic                         cfg_wr;
  logic                         cfg_sel_extra;

  assign cfg_pready    = 1'b1;
  assign cfg_sel_extra = (cfg_paddr[scot_pkg::CFG_ADDR_W-1] == scot_pkg::REG_EXTRA_RADIUS);
  assign cfg_wr        = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    extra_nxt = extra_r;
    if (cfg_wr && cfg_sel_extra) begin
      extra_nxt = cfg_pwdata[scot_pkg::EXTRA_W-1:0];
    end
  end

  // Read back: unknown addresses read as zero
  assign cfg_prdata = cfg_sel_extra
                    ? {{(scot_pkg::CFG_DATA_W-scot_pkg::EXTRA_W){1'b0}}, extra_r}
                    : '0;

  // Stage valid bits and per-stage load enables
  logic [NS-1:0] vld_r, vld_nxt;
  logic [NS-1:0] adv;

  // The last stage is the output register: advance it when empty or taken
  assign adv[NS-1] = !vld_r[NS-1] || out_tready;

  // Any earlier stage advances when empty or when the next one advances
  for (genvar g = 0; g < NS - 1; g++) begin : g_adv
    assign adv[g] = !vld_r[g] || adv[g+1];
  end

  always_comb begin
    vld_nxt[0] = adv[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < NS; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      extra_r <= scot_pkg::EXTRA_RESET;
    end else begin
      vld_r   <= vld_nxt;
      extra_r <= extra_nxt;
    end
  end

  // Datapath
  scot_pkg::scot_item_t item;
  logic                 hit;

  assign item = scot_pkg::scot_item_t'(in_tdata);

  scot_datapath u_dp (
    .clk   (clk),
    .en    (adv),
    .item  (item),
    .extra (extra_r),
    .hit   (hit)
  );

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = {{(scot_pkg::OUT_TDATA_W-1){1'b0}}, hit};

endmodule

>>> src/scot_datapath.sv
// ----------------------------------------------------------------------------
// Sphere-capsule overlap test datapath
// Eight register stages from coordinate differences to the hit bit.
// ----------------------------------------------------------------------------
module scot_datapath (
  input  logic                                clk,
  input  logic [scot_pkg::NUM_STAGES-1:0]     en,       // load enable per stage
  input  scot_pkg::scot_item_t                item,
  input  logic [scot_pkg::EXTRA_W-1:0]        extra,
  output logic                                hit
);

  localparam int DW  = scot_pkg::DIFF_W;
  localparam int PW  = scot_pkg::PROD_W;
  localparam int HW  = scot_pkg::HALF_W;

  logic signed [scot_pkg::COORD_W-1:0] st [3];
  logic signed [scot_pkg::COORD_W-1:0] en_pt [3];
  logic signed [scot_pkg::COORD_W-1:0] pt [3];

  assign st[0]    = item.start_x;
  assign st[1]    = item.start_y;
  assign st[2]    = item.start_z;
  assign en_pt[0] = item.end_x;
  assign en_pt[1] = item.end_y;
  assign en_pt[2] = item.end_z;
  assign pt[0]    = item.point_x;
  assign pt[1]    = item.point_y;
  assign pt[2]    = item.point_z;

  // Stage 1: axis, start-to-point and point-to-end vectors, combined radius
  logic signed [DW-1:0]             s1_ax_r [3];
  logic signed [DW-1:0]             s1_ps_r [3];
  logic signed [DW-1:0]             s1_ep_r [3];
  logic [scot_pkg::RAD_W-1:0]       s1_rad_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        s1_ax_r[k] <= scot_pkg::sdiff(en_pt[k], st[k]);
        s1_ps_r[k] <= scot_pkg::sdiff(pt[k], st[k]);
        s1_ep_r[k] <= scot_pkg::sdiff(en_pt[k], pt[k]);
      end
      s1_rad_r <= {1'b0, item.radius}
                + {{(scot_pkg::RAD_W-scot_pkg::EXTRA_W){1'b0}}, extra};
    end
  end

  // Stage 2: all signed 25x25 products and the radius square
  logic signed [PW-1:0]             s2_aps_r  [3];
  logic signed [PW-1:0]             s2_psps_r [3];
  logic signed [PW-1:0]             s2_aep_r  [3];
  logic signed [PW-1:0]             s2_epep_r [3];
  logic signed [PW-1:0]             s2_aa_r   [3];
  logic signed [PW-1:0]             s2_cpa_r  [3];
  logic signed [PW-1:0]             s2_cpb_r  [3];
  logic [scot_pkg::RR_W-1:0]        s2_rr_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        s2_aps_r[k]  <= scot_pkg::smul(s1_ax_r[k], s1_ps_r[k]);
        s2_psps_r[k] <= scot_pkg::smul(s1_ps_r[k], s1_ps_r[k]);
        s2_aep_r[k]  <= scot_pkg::smul(s1_ax_r[k], s1_ep_r[k]);
        s2_epep_r[k] <= scot_pkg::smul(s1_ep_r[k], s1_ep_r[k]);
        s2_aa_r[k]   <= scot_pkg::smul(s1_ax_r[k], s1_ax_r[k]);
      end
      s2_cpa_r[0] <= scot_pkg::smul(s1_ax_r[1], s1_ep_r[2]);
      s2_cpb_r[0] <= scot_pkg::smul(s1_ax_r[2], s1_ep_r[1]);
      s2_cpa_r[1] <= scot_pkg::smul(s1_ax_r[2], s1_ep_r[0]);
      s2_cpb_r[1] <= scot_pkg::smul(s1_ax_r[0], s1_ep_r[2]);
      s2_cpa_r[2] <= scot_pkg::smul(s1_ax_r[0], s1_ep_r[1]);
      s2_cpb_r[2] <= scot_pkg::smul(s1_ax_r[1], s1_ep_r[0]);
      s2_rr_r     <= scot_pkg::rmul(s1_rad_r, s1_rad_r);
    end
  end

  // Stage 3: dot products and cross components
  logic signed [scot_pkg::DOT_W-1:0]   s3_aps_r, s3_psps_r, s3_aep_r, s3_epep_r, s3_aa_r;
  logic signed [scot_pkg::CROSS_W-1:0] s3_cr_r [3];
  logic [scot_pkg::RR_W-1:0]           s3_rr_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_aps_r  <= scot_pkg::sum3(s2_aps_r[0],  s2_aps_r[1],  s2_aps_r[2]);
      s3_psps_r <= scot_pkg::sum3(s2_psps_r[0], s2_psps_r[1], s2_psps_r[2]);
      s3_aep_r  <= scot_pkg::sum3(s2_aep_r[0],  s2_aep_r[1],  s2_aep_r[2]);
      s3_epep_r <= scot_pkg::sum3(s2_epep_r[0], s2_epep_r[1], s2_epep_r[2]);
      s3_aa_r   <= scot_pkg::sum3(s2_aa_r[0],   s2_aa_r[1],   s2_aa_r[2]);
      for (int k = 0; k < 3; k++) begin
        s3_cr_r[k] <= scot_pkg::csub(s2_cpa_r[k], s2_cpb_r[k]);
      end
      s3_rr_r <= s2_rr_r;
    end
  end

  // Stage 4: end-cap tests, cross magnitudes
  logic signed [scot_pkg::DOT_W-1:0] rr_wide;
  logic                              cap_miss;

  assign rr_wide  = $signed({{(scot_pkg::DOT_W-scot_pkg::RR_W){1'b0}}, s3_rr_r});
  assign cap_miss = (s3_aps_r[scot_pkg::DOT_W-1] && (s3_psps_r > rr_wide))
                 || (s3_aep_r[scot_pkg::DOT_W-1] && (s3_epep_r > rr_wide));

  logic [scot_pkg::ABS_W-1:0]  s4_cabs_r [3];
  logic [scot_pkg::AA_W-1:0]   s4_aa_r;
  logic [scot_pkg::RR_W-1:0]   s4_rr_r;
  logic                        s4_miss_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        s4_cabs_r[k] <= scot_pkg::sabs(s3_cr_r[k]);
      end
      s4_aa_r   <= s3_aa_r[scot_pkg::AA_W-1:0];
      s4_rr_r   <= s3_rr_r;
      s4_miss_r <= cap_miss;
    end
  end

  // Stage 5: partial products of the squares and of the limit
  logic [HW-1:0] rr_hi, rr_lo, aa_hi, aa_lo;

  assign rr_hi = {{(2*HW-scot_pkg::RR_W){1'b0}}, s4_rr_r[scot_pkg::RR_W-1:HW]};
  assign rr_lo = s4_rr_r[HW-1:0];
  assign aa_hi = s4_aa_r[scot_pkg::AA_W-1:HW];
  assign aa_lo = s4_aa_r[HW-1:0];

  logic [scot_pkg::PP_W-1:0] s5_hh_r [3];
  logic [scot_pkg::PP_W-1:0] s5_hl_r [3];
  logic [scot_pkg::PP_W-1:0] s5_ll_r [3];
  logic [scot_pkg::PP_W-1:0] s5_lim_hh_r, s5_lim_hl_r, s5_lim_lh_r, s5_lim_ll_r;
  logic                      s5_miss_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < 3; k++) begin
        s5_hh_r[k] <= scot_pkg::umul(s4_cabs_r[k][scot_pkg::ABS_W-1:HW],
                                     s4_cabs_r[k][scot_pkg::ABS_W-1:HW]);
        s5_hl_r[k] <= scot_pkg::umul(s4_cabs_r[k][scot_pkg::ABS_W-1:HW],
                                     s4_cabs_r[k][HW-1:0]);
        s5_ll_r[k] <= scot_pkg::umul(s4_cabs_r[k][HW-1:0], s4_cabs_r[k][HW-1:0]);
      end
      s5_lim_hh_r <= scot_pkg::umul(rr_hi, aa_hi);
      s5_lim_hl_r <= scot_pkg::umul(rr_hi, aa_lo);
      s5_lim_lh_r <= scot_pkg::umul(rr_lo, aa_hi);
      s5_lim_ll_r <= scot_pkg::umul(rr_lo, aa_lo);
      s5_miss_r   <= s4_miss_r;
    end
  end

  // Stage 6: reassemble squares and limit; the cross term of a square is doubled
  localparam int PPW = scot_pkg::PP_W;
  localparam int WW  = scot_pkg::WIDE_W;

  logic [WW-1:0] s6_sq_r [3];
  logic [WW-1:0] s6_lim_r;
  logic          s6_miss_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int k = 0; k < 3; k++) begin
        s6_sq_r[k] <= {s5_hh_r[k], {PPW{1'b0}}}
                    + {{(WW-PPW-HW-1){1'b0}}, s5_hl_r[k], {(HW+1){1'b0}}}
                    + {{(WW-PPW){1'b0}}, s5_ll_r[k]};
      end
      s6_lim_r <= {s5_lim_hh_r, {PPW{1'b0}}}
                + {{(WW-PPW-HW){1'b0}}, s5_lim_hl_r, {HW{1'b0}}}
                + {{(WW-PPW-HW){1'b0}}, s5_lim_lh_r, {HW{1'b0}}}
                + {{(WW-PPW){1'b0}}, s5_lim_ll_r};
      s6_miss_r <= s5_miss_r;
    end
  end

  // Stage 7: squared cross length
  localparam int SW = scot_pkg::WSUM_W;

  logic [SW-1:0] s7_sum_r;
  logic [WW-1:0] s7_lim_r;
  logic          s7_miss_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_sum_r  <= {{(SW-WW){1'b0}}, s6_sq_r[0]}
                 + {{(SW-WW){1'b0}}, s6_sq_r[1]}
                 + {{(SW-WW){1'b0}}, s6_sq_r[2]};
      s7_lim_r  <= s6_lim_r;
      s7_miss_r <= s6_miss_r;
    end
  end

  // Stage 8: line-distance test, final answer
  logic s8_hit_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_hit_r <= !s7_miss_r && !(s7_sum_r > {{(SW-WW){1'b0}}, s7_lim_r});
    end
  end

  assign hit = s8_hit_r;

endmodule

>>> src/scot_checker.sv
// ----------------------------------------------------------------------------
// Sphere-capsule overlap test checker
// Port-level properties of the unit, attached by bind.
// ----------------------------------------------------------------------------
`include "sphere_capsule_overlap_test_unit_defines.svh"

module scot_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [scot_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [scot_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [scot_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  input  logic [scot_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  input  logic                                cfg_pready
);

  logic                         in_acc;
  logic                         sel_extra;
  logic                         cfg_wr_extra;
  logic [scot_pkg::EXTRA_W-1:0] rd_extra;
  logic [scot_pkg::EXTRA_W-1:0] wr_extra;

  assign in_acc       = in_tvalid && in_tready;
  assign sel_extra    = (cfg_paddr[scot_pkg::CFG_ADDR_W-1] == scot_pkg::REG_EXTRA_RADIUS);
  assign cfg_wr_extra = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_extra;
  assign rd_extra     = cfg_prdata[scot_pkg::EXTRA_W-1:0];
  assign wr_extra     = cfg_pwdata[scot_pkg::EXTRA_W-1:0];

  // Hold a stalled result word
  `SCOT_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word changed while stalled")

  // An empty output register never blocks the input
  `SCOT_ASSERT_IMP(a_in_ready, !out_tvalid, in_tready, "input stalled with empty output")

  // With out_tready held high after acceptance, a result is offered on out_tvalid
  `SCOT_ASSERT_NXT(a_latency, in_acc ##1 out_tready [*7], out_tvalid, "result missing")

  // A write to extra_radius reads back from the register once it has been taken
  `SCOT_ASSERT_NXT(a_cfg_readback, cfg_wr_extra, !sel_extra || (rd_extra == $past(wr_extra)), "bad readback")

endmodule

bind sphere_capsule_overlap_test_unit scot_checker u_scot_checker (.*);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// Sphere-capsule overlap test unit testbench
// Streams capsule/sphere queries through the unit, works out the expected hit
// bit for every accepted query with exact wide integer geometry, and compares
// it against each result word in order. The extra_radius register is changed
// between phases while the unit idles. Both stream sides idle at random.
// ----------------------------------------------------------------------------

// Expected hit bits, in query order, plus the register copy they depend on.
class hit_scoreboard;
  logic [scot_pkg::EXTRA_W-1:0] extra_radius;
  bit                           hits_due[$];
  int unsigned                  errors;

  function new();
    extra_radius = scot_pkg::EXTRA_RESET;
    errors       = 0;
  endfunction

  // Exact test: cap checks on both ends, then the squared distance from the
  // axis line compared without a division.
  function bit predict_hit(scot_pkg::scot_item_t q);
    logic signed [127:0] ax [3];
    logic signed [127:0] ps [3];
    logic signed [127:0] ep [3];
    logic signed [127:0] cr [3];
    logic signed [127:0] rad, rr, lim;
    logic signed [127:0] cap_s, dist_s, cap_e, dist_e, cross2, axis2;
    longint s [3];
    longint e [3];
    longint p [3];
    int k;
    bit hit;
    s[0] = q.start_x; s[1] = q.start_y; s[2] = q.start_z;
    e[0] = q.end_x;   e[1] = q.end_y;   e[2] = q.end_z;
    p[0] = q.point_x; p[1] = q.point_y; p[2] = q.point_z;
    for (k = 0; k < 3; k++) begin
      ax[k] = e[k] - s[k];
      ps[k] = p[k] - s[k];
      ep[k] = e[k] - p[k];
    end
    rad    = q.radius + extra_radius;
    rr     = rad * rad;
    cap_s  = ax[0] * ps[0] + ax[1] * ps[1] + ax[2] * ps[2];
    dist_s = ps[0] * ps[0] + ps[1] * ps[1] + ps[2] * ps[2];
    cap_e  = ax[0] * ep[0] + ax[1] * ep[1] + ax[2] * ep[2];
    dist_e = ep[0] * ep[0] + ep[1] * ep[1] + ep[2] * ep[2];
    cr[0]  = ax[1] * ep[2] - ax[2] * ep[1];
    cr[1]  = ax[2] * ep[0] - ax[0] * ep[2];
    cr[2]  = ax[0] * ep[1] - ax[1] * ep[0];
    cross2 = cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2];
    axis2  = ax[0] * ax[0] + ax[1] * ax[1] + ax[2] * ax[2];
    lim    = rr * axis2;
    hit = 1'b1;
    if (cap_s < 0 && dist_s > rr) hit = 1'b0;
    if (cap_e < 0 && dist_e > rr) hit = 1'b0;
    if (cross2 > lim) hit = 1'b0;
    return hit;
  endfunction

  function void note_query(scot_pkg::scot_item_t q);
    hits_due.push_back(predict_hit(q));
  endfunction

  function int pending();
    return hits_due.size();
  endfunction

  task report(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  task check_hit(logic [scot_pkg::OUT_TDATA_W-1:0] word);
    bit due;
    if (hits_due.size() == 0) begin
      report("result word with no query waiting");
      return;
    end
    due = hits_due.pop_front();
    if (word[0] !== due)
      report($sformatf("hit is %b, expected %b", word[0], due));
  endtask

  task close();
    if (hits_due.size() != 0)
      report($sformatf("%0d result words never arrived", hits_due.size()));
  endtask
endclass

module tb_top;
  import scot_pkg::*;

  localparam longint      MAXC          = 64'sd8388607;
  localparam longint      MINC          = -64'sd8388608;
  localparam longint      MAXR          = 64'sd8388607;
  localparam longint      HALF_RANGE    = 64'sd4194304;
  localparam longint      EDGE_LEN      = 64'sd1000;
  localparam int          RANDOM_PER_PH = 255;
  localparam int          NUM_PHASES    = 6;
  localparam int          SETTLE_CYCLES = 16;
  localparam int unsigned STALL_LIMIT   = 2000;
  // Index one past the register map: writes there must be dropped
  localparam logic [0:0]  REG_UNMAPPED  = 1'b1;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;     // start_x .. point_z, radius, pad
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;    // hit, pad
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  hit_scoreboard sb = new();
  bit            tx_burst = 1'b0;
  bit            rx_burst = 1'b0;
  int unsigned   quiet_cycles = 0;

  sphere_capsule_overlap_test_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // Note every accepted query word and check every accepted result word.
  // Both sample the values that the unit itself saw at this edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_query(in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_hit(out_tdata);
  end

  // Watchdog: end the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: hold tready low for a random number of cycles before each
  // word, except during bursts where it stays high throughout.
  initial begin
    int unsigned gap;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = rx_burst ? 0 : $urandom_range(4);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      if ($urandom_range(39) == 0) rx_burst = !rx_burst;
    end
  end

  function automatic scot_item_t make_query(longint sx, longint sy, longint sz,
                                            longint ex, longint ey, longint ez,
                                            longint px, longint py, longint pz,
                                            longint rad);
    scot_item_t q;
    q         = '0;
    q.start_x = sx[COORD_W-1:0];
    q.start_y = sy[COORD_W-1:0];
    q.start_z = sz[COORD_W-1:0];
    q.end_x   = ex[COORD_W-1:0];
    q.end_y   = ey[COORD_W-1:0];
    q.end_z   = ez[COORD_W-1:0];
    q.point_x = px[COORD_W-1:0];
    q.point_y = py[COORD_W-1:0];
    q.point_z = pz[COORD_W-1:0];
    q.radius  = rad[RADIUS_W-1:0];
    return q;
  endfunction

  // Every bit of every field drawn at random; the pad bit stays clear.
  function automatic scot_item_t raw_query();
    logic [IN_TDATA_W-1:0] bits;
    scot_item_t q;
    int i;
    for (i = 0; i < IN_TDATA_W / 32; i++) bits[i*32 +: 32] = $urandom();
    bits[IN_TDATA_W-1 -: 16] = 16'($urandom());
    q     = bits;
    q.pad = 1'b0;
    return q;
  endfunction

  function automatic longint spread(longint span);
    return longint'($urandom_range(32'(2 * span))) - span;
  endfunction

  // Capsule of random scale somewhere in the middle of the range, with the
  // sphere centre near it, so hits and misses both turn up often.
  function automatic scot_item_t local_query();
    longint span, bx, by, bz, sx, sy, sz, ex, ey, ez;
    span = 64'sd1 << $urandom_range(20, 1);
    bx = longint'($urandom_range(8388607)) - HALF_RANGE;
    by = longint'($urandom_range(8388607)) - HALF_RANGE;
    bz = longint'($urandom_range(8388607)) - HALF_RANGE;
    sx = bx + spread(span); sy = by + spread(span); sz = bz + spread(span);
    ex = sx + spread(span); ey = sy + spread(span); ez = sz + spread(span);
    return make_query(sx, sy, sz, ex, ey, ez,
                      sx + spread(span), sy + spread(span), sz + spread(span),
                      longint'($urandom_range(32'(span))));
  endfunction

  // Axis along one coordinate axis, centre placed one step inside, on, or
  // one step outside the combined radius: beside the axis or past a cap.
  function automatic scot_item_t edge_query();
    longint sv [3];
    longint ev [3];
    longint pv [3];
    longint rad, big_r, len, base, off;
    int a, b, k;
    rad   = $urandom_range(4095);
    big_r = rad + sb.extra_radius;
    len   = $urandom_range(4096);
    off   = big_r + longint'($urandom_range(2)) - 1;
    a     = $urandom_range(2);
    b     = (a + 1 + $urandom_range(1)) % 3;
    for (k = 0; k < 3; k++) begin
      base  = longint'($urandom_range(8388607)) - HALF_RANGE;
      sv[k] = base;
      ev[k] = base;
      pv[k] = base;
    end
    ev[a] += len;
    case ($urandom_range(2))
      0: begin
        pv[a] += longint'($urandom_range(32'(len)));
        pv[b] += $urandom_range(1) ? off : -off;
      end
      1: pv[a] = sv[a] - off;
      default: pv[a] = ev[a] + off;
    endcase
    return make_query(sv[0], sv[1], sv[2], ev[0], ev[1], ev[2],
                      pv[0], pv[1], pv[2], rad);
  endfunction

  function automatic scot_item_t random_query();
    scot_item_t q;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      q = raw_query();
    end else if (pick < 40) begin
      // zero-length axis: always a hit, wherever the centre is
      q = raw_query();
      q.end_x = q.start_x;
      q.end_y = q.start_y;
      q.end_z = q.start_z;
    end else if (pick < 75) begin
      q = local_query();
    end else begin
      q = edge_query();
    end
    return q;
  endfunction

  // Offer one query word after a random gap and hold it until accepted.
  task automatic send_query(input scot_item_t q);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(4);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= q;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    if ($urandom_range(39) == 0) tx_burst = !tx_burst;
  endtask

  // Stop offering and wait until every expected word has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Register write with a setup and an access phase; the register copy follows once it lands.
  task automatic write_reg(input logic [0:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_EXTRA_RADIUS) sb.extra_radius = value[EXTRA_W-1:0];
  endtask

  // Directed queries: range extremes, zero-length axis, and centres exactly
  // on and one step beyond the combined radius beside the axis and past
  // either cap.
  task automatic run_directed();
    longint rad, r;
    rad = 360;
    r   = rad + sb.extra_radius;
    send_query(make_query(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXR));
    send_query(make_query(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, 0));
    send_query(make_query(MINC, MINC, MINC, MAXC, MAXC, MAXC, 0, 0, 0, 0));
    send_query(make_query(MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, 0, MAXR));
    send_query(make_query(MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC, MINC, 0));
    send_query(make_query(MINC, 0, MAXC, MAXC, 0, MINC, MAXC, MAXC, MINC, MAXR));
    send_query(make_query(0, 0, 0, 0, 0, 0, MAXC, MINC, MAXC, 0));
    send_query(make_query(0, 0, 0, EDGE_LEN, 0, 0, EDGE_LEN / 2, 0, 0, 0));
    send_query(make_query(0, 0, 0, EDGE_LEN, 0, 0, EDGE_LEN / 2, r, 0, rad));
    send_query(make_query(0, 0, 0, EDGE_LEN, 0, 0, EDGE_LEN / 2, r + 1, 0, rad));
    send_query(make_query(0, 0, 0, EDGE_LEN, 0, 0, -r, 0, 0, rad));
    send_query(make_query(0, 0, 0, EDGE_LEN, 0, 0, -r - 1, 0, 0, rad));
    send_query(make_query(0, 0, 0, EDGE_LEN, 0, 0, EDGE_LEN + r, 0, 0, rad));
    send_query(make_query(0, 0, 0, EDGE_LEN, 0, 0, EDGE_LEN + r + 1, 0, 0, rad));
    send_query(make_query(0, 0, 0, EDGE_LEN, 0, 0, 0, 0, r, rad));
    send_query(make_query(0, 0, 0, EDGE_LEN, 0, 0, 0, 0, r + 1, rad));
    send_query(make_query(0, 0, 0, EDGE_LEN, 0, 0, EDGE_LEN, -r, 0, rad));
    send_query(make_query(0, 0, 0, EDGE_LEN, 0, 0, EDGE_LEN + 1, -r, 0, rad));
  endtask

  initial begin
    int ph, n;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // Registers change only with the pipeline empty
      if (ph != 0) begin
        wait_drained();
        repeat (2) @(posedge clk);
        case (ph)
          1: write_reg(REG_EXTRA_RADIUS, {16'($urandom()), 16'h0000});
          2: write_reg(REG_EXTRA_RADIUS, {16'($urandom()), 16'hFFFF});
          3: write_reg(REG_EXTRA_RADIUS, $urandom());
          4: write_reg(REG_UNMAPPED, $urandom());
          default: write_reg(REG_EXTRA_RADIUS, {16'h0000, 16'($urandom_range(4095))});
        endcase
      end
      if (ph == 0) run_directed();
      for (n = 0; n < RANDOM_PER_PH; n++) begin
        send_query(random_query());
        // now and then let the pipeline run dry mid-phase
        if ($urandom_range(149) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.close();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+src
src/scot_pkg.sv
src/scot_datapath.sv
src/sphere_capsule_overlap_test_unit.sv
src/scot_checker.sv
dv/tb_top.sv
